[rtl/bounded_ordered_list_engine_defines.svh]
// Assertion macros for the bounded ordered list engine checker.
// Depends on nothing; included by the checker file only.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication under clk, disabled in reset.
`define BOLE_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under clk, disabled in reset.
`define BOLE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bole_pkg.sv]
// Shared constants and types for the bounded ordered list engine.
// No dependencies.
package bole_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 16;

  localparam logic [3:0] MODE_CLEAR   = 4'd0;
  localparam logic [3:0] MODE_PUSH_FR = 4'd1;
  localparam logic [3:0] MODE_PUSH_BK = 4'd2;
  localparam logic [3:0] MODE_POP_FR  = 4'd3;
  localparam logic [3:0] MODE_POP_BK  = 4'd4;
  localparam logic [3:0] MODE_REMOVE  = 4'd5;
  localparam logic [3:0] MODE_FIND    = 4'd6;
  localparam logic [3:0] MODE_COUNT   = 4'd7;
  localparam logic [3:0] MODE_LIST    = 4'd8;

  localparam logic [2:0] KIND_EMPTY    = 3'd0;
  localparam logic [2:0] KIND_NOTFOUND = 3'd1;
  localparam logic [2:0] KIND_INVALID  = 3'd2;
  localparam logic [2:0] KIND_POSITION = 3'd3;
  localparam logic [2:0] KIND_COUNT    = 3'd4;
  localparam logic [2:0] KIND_ELEMENT  = 3'd5;
  localparam logic [2:0] KIND_FULL     = 3'd6;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] number;
    logic                     last;
  } result_t;

endpackage

[rtl/bole_if.sv]
// Request and response channel interfaces for the list engine.
// Depends on bole_pkg.
interface bole_req_if;
  logic                               valid;
  logic                               ready;
  logic [3:0]                         mode;
  logic signed [bole_pkg::DATA_W-1:0] value;

  modport source (output valid, mode, value, input ready);
  modport sink (input valid, mode, value, output ready);
endinterface

interface bole_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         kind;
  logic signed [bole_pkg::DATA_W-1:0] number;
  logic                               last;

  modport source (output valid, kind, number, last, input ready);
  modport sink (input valid, kind, number, last, output ready);
endinterface

[rtl/bounded_ordered_list_engine.sv]
// Top level of the bounded ordered list engine.
// Depends on bole_pkg, bole_if, bole_mem, bole_seq and bole_obuf.
//
// Keeps up to CAPACITY signed 32-bit values in list order in a single-port-
// write, single-port-read memory with registered read data; index 0 is the
// front. One request is worked at a time. Clear, push back, pop back, count,
// invalid modes, a push front into an empty list and every request that
// ends in an empty or full status finish without leaving the idle state.
// Push front moves each stored element up one slot, a read and a write per
// element, then writes the new value to slot 0. Pop front closes the gap,
// a read and a write per element moved. Remove and find scan from the
// front, a read and a compare per element visited; a remove then closes the
// gap behind the hit the same way. List streams one beat per element, the
// last beat marked. A result waits in an output register. A new request is
// taken only when that register is empty or its beat is taken in the same
// cycle, so a stalled response channel holds the request channel as well as
// scans and listings.
// The store needs no clearing pass after reset: only entries below the
// count are ever read.
module bounded_ordered_list_engine #(
  parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  bole_req_if.sink   req,
  bole_rsp_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [bole_pkg::DATA_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [bole_pkg::DATA_W-1:0] mem_rdata;
  logic                        slot_free;
  logic                        emit;
  bole_pkg::result_t           res;
  bole_pkg::result_t           rsp_data;

  bole_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bole_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_mode   (req.mode),
    .in_value  (req.value),
    .slot_free (slot_free),
    .emit      (emit),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Hold the result until the response beat is taken.
  bole_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .res       (res),
    .slot_free (slot_free),
    .valid     (rsp.valid),
    .ready     (rsp.ready),
    .data      (rsp_data)
  );

  assign rsp.kind   = rsp_data.kind;
  assign rsp.number = rsp_data.number;
  assign rsp.last   = rsp_data.last;

endmodule

[rtl/bole_mem.sv]
// Element store: one write port, one read port, registered read data.
// Depends on bole_pkg.
module bole_mem #(
  parameter int DEPTH = bole_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [bole_pkg::DATA_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [bole_pkg::DATA_W-1:0] rdata
);

  logic [bole_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data between reads.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/bole_obuf.sv]
// Output register between the sequencer and the response channel.
// Depends on bole_pkg.
module bole_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              emit,
  input  bole_pkg::result_t res,
  output logic              slot_free,
  output logic              valid,
  input  logic              ready,
  output bole_pkg::result_t data
);

  assign slot_free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (emit) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      data <= res;
    end
  end

endmodule

[rtl/bole_seq.sv]
// Request sequencer: decodes a request and walks the element store.
// Depends on bole_pkg; drives bole_mem and bole_obuf.
module bole_seq #(
  parameter int CAPACITY = bole_pkg::CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [3:0]                         in_mode,
  input  logic signed [bole_pkg::DATA_W-1:0] in_value,
  input  logic                               slot_free,
  output logic                               emit,
  output bole_pkg::result_t                  res,
  output logic                               mem_we,
  output logic [AW-1:0]                      mem_waddr,
  output logic [bole_pkg::DATA_W-1:0]        mem_wdata,
  output logic                               mem_re,
  output logic [AW-1:0]                      mem_raddr,
  input  logic [bole_pkg::DATA_W-1:0]        mem_rdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_SHUP_RD, S_SHUP_WR, S_PF_WR, S_SHDN_RD, S_SHDN_WR,
    S_SCAN_RD, S_SCAN_CMP, S_LIST_RD, S_LIST_EM
  } state_t;

  state_t                      state;
  logic [CW-1:0]               cnt;
  logic [AW-1:0]               ptr;
  logic                        is_find;
  logic [bole_pkg::DATA_W-1:0] val;
  logic [CW-1:0]               ptr_inc;
  logic                        accept;
  logic                        at_end;

  assign ptr_inc  = CW'(ptr) + CW'(1);
  assign at_end   = (ptr_inc == cnt);
  assign in_ready = (state == S_IDLE) && slot_free;
  assign accept   = in_valid && in_ready;

  // Store access per state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = ptr;
    unique case (state)
      S_IDLE: begin
        mem_waddr = AW'(cnt);
        mem_wdata = in_value;
        mem_we    = accept && (in_mode == bole_pkg::MODE_PUSH_BK)
                    && (cnt != CW'(CAPACITY));
        if (accept && (in_mode == bole_pkg::MODE_PUSH_FR) && (cnt == '0)) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
        end
      end
      S_SHUP_RD, S_SCAN_RD, S_LIST_RD: mem_re = 1'b1;
      S_SHUP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(ptr_inc);
      end
      S_PF_WR: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = val;
      end
      S_SHDN_RD: begin
        mem_re    = !at_end;
        mem_raddr = AW'(ptr_inc);
      end
      S_SHDN_WR: mem_we = 1'b1;
      default: ;
    endcase
  end

  // Result to the output register.
  always_comb begin
    emit = 1'b0;
    res  = '{kind: bole_pkg::KIND_EMPTY, number: '0, last: 1'b1};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            bole_pkg::MODE_CLEAR: ;
            bole_pkg::MODE_PUSH_FR, bole_pkg::MODE_PUSH_BK: begin
              emit     = (cnt == CW'(CAPACITY));
              res.kind = bole_pkg::KIND_FULL;
            end
            bole_pkg::MODE_POP_FR, bole_pkg::MODE_POP_BK, bole_pkg::MODE_REMOVE,
            bole_pkg::MODE_FIND, bole_pkg::MODE_LIST: emit = (cnt == '0);
            bole_pkg::MODE_COUNT: begin
              emit       = 1'b1;
              res.kind   = bole_pkg::KIND_COUNT;
              res.number = bole_pkg::DATA_W'(cnt);
            end
            default: begin
              emit     = 1'b1;
              res.kind = bole_pkg::KIND_INVALID;
            end
          endcase
        end
      end
      S_SCAN_CMP: begin
        if (slot_free) begin
          if (mem_rdata == val) begin
            emit       = is_find;
            res.kind   = bole_pkg::KIND_POSITION;
            res.number = bole_pkg::DATA_W'(ptr_inc);
          end else begin
            emit     = at_end;
            res.kind = bole_pkg::KIND_NOTFOUND;
          end
        end
      end
      S_LIST_EM: begin
        emit       = slot_free;
        res.kind   = bole_pkg::KIND_ELEMENT;
        res.number = mem_rdata;
        res.last   = at_end;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            val     <= in_value;
            ptr     <= '0;
            is_find <= (in_mode == bole_pkg::MODE_FIND);
            case (in_mode)
              bole_pkg::MODE_CLEAR: cnt <= '0;
              bole_pkg::MODE_PUSH_FR: begin
                if (cnt == '0) begin
                  cnt <= CW'(1);
                end else if (cnt != CW'(CAPACITY)) begin
                  ptr   <= AW'(cnt - CW'(1));
                  state <= S_SHUP_RD;
                end
              end
              bole_pkg::MODE_PUSH_BK: begin
                if (cnt != CW'(CAPACITY)) cnt <= cnt + CW'(1);
              end
              bole_pkg::MODE_POP_FR: if (cnt != '0) state <= S_SHDN_RD;
              bole_pkg::MODE_POP_BK: if (cnt != '0) cnt <= cnt - CW'(1);
              bole_pkg::MODE_REMOVE, bole_pkg::MODE_FIND: begin
                if (cnt != '0) state <= S_SCAN_RD;
              end
              bole_pkg::MODE_LIST: if (cnt != '0) state <= S_LIST_RD;
              default: ;
            endcase
          end
        end
        S_SHUP_RD: state <= S_SHUP_WR;
        S_SHUP_WR: begin
          if (ptr == '0) begin
            state <= S_PF_WR;
          end else begin
            ptr   <= ptr - AW'(1);
            state <= S_SHUP_RD;
          end
        end
        S_PF_WR: begin
          cnt   <= cnt + CW'(1);
          state <= S_IDLE;
        end
        S_SHDN_RD: begin
          if (at_end) begin
            cnt   <= cnt - CW'(1);
            state <= S_IDLE;
          end else begin
            state <= S_SHDN_WR;
          end
        end
        S_SHDN_WR: begin
          ptr   <= AW'(ptr_inc);
          state <= S_SHDN_RD;
        end
        S_SCAN_RD: state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (mem_rdata == val) begin
            // Hit: report position, or close the gap from here.
            if (!is_find) begin
              state <= S_SHDN_RD;
            end else if (slot_free) begin
              state <= S_IDLE;
            end
          end else if (at_end) begin
            if (slot_free) state <= S_IDLE;
          end else begin
            ptr   <= AW'(ptr_inc);
            state <= S_SCAN_RD;
          end
        end
        S_LIST_RD: state <= S_LIST_EM;
        S_LIST_EM: begin
          if (slot_free) begin
            if (at_end) begin
              state <= S_IDLE;
            end else begin
              ptr   <= AW'(ptr_inc);
              state <= S_LIST_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/bole_chk.sv]
// Port-level checker for the list engine, bound to the top level.
// Depends on bole_pkg and bounded_ordered_list_engine_defines.svh.
`include "bounded_ordered_list_engine_defines.svh"

module bole_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic [2:0]                         rsp_kind,
  input logic signed [bole_pkg::DATA_W-1:0] rsp_number,
  input logic                               rsp_last
);

  logic                          stalled;
  logic                          is_status;
  logic                          is_pos;
  logic [bole_pkg::DATA_W+3:0]   rsp_word;

  assign stalled   = rsp_valid && !rsp_ready;
  assign is_status = rsp_valid && (rsp_kind == bole_pkg::KIND_EMPTY ||
                     rsp_kind == bole_pkg::KIND_NOTFOUND ||
                     rsp_kind == bole_pkg::KIND_INVALID ||
                     rsp_kind == bole_pkg::KIND_FULL);
  assign is_pos    = rsp_valid && (rsp_kind == bole_pkg::KIND_POSITION);
  assign rsp_word  = {rsp_kind, rsp_number, rsp_last};

  `BOLE_ASSERT_NEXT(a_rsp_hold, clk, rst, stalled, rsp_valid && $stable(rsp_word),
                    "response changed while stalled")
  `BOLE_ASSERT_NOW(a_status_zero, clk, rst, is_status, rsp_number == '0 && rsp_last,
                   "status beat with nonzero number or not last")
  `BOLE_ASSERT_NOW(a_pos_nonzero, clk, rst, is_pos, rsp_number > 0 && rsp_last,
                   "bad position beat")
  `BOLE_ASSERT_NOW(a_kind_range, clk, rst, rsp_valid, rsp_kind != 3'd7,
                   "undefined result kind")

endmodule

bind bounded_ordered_list_engine bole_chk u_bole_chk (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_kind   (rsp.kind),
  .rsp_number (rsp.number),
  .rsp_last   (rsp.last)
);
